>>> src/text_console_writer_top_macros.svh
// Assertion macros shared by the text console writer RTL.
// Used inside modules that have i_clk and i_rst_n in scope; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tcw_pkg.sv
// Text console writer package: screen geometry, field widths, codes and command type.
// No dependencies.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_BLANKS = 4;
    localparam int CELLS      = ROWS * COLUMNS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int MEM_AW = $clog2(CELLS);
    // walk address may run a few cells past the end during a tab
    localparam int WALK_W = $clog2(CELLS + TAB_BLANKS + 1);
    localparam int CNT_W  = $clog2(TAB_BLANKS + 1);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [7:0] CHAR_NEWLINE     = 8'd10;
    localparam logic [7:0] CHAR_TAB         = 8'd9;
    localparam logic [7:0] CHAR_BLANK       = 8'h20;
    localparam logic [7:0] CHAR_NULL        = 8'h00;

    localparam logic [1:0] FUNC_PUT    = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_SETCUR = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_TAB,
        OP_DELETE,
        OP_SETCUR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [7:0]       ch;
        logic [7:0]       attr;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

`default_nettype wire

>>> src/tcw_front.sv
// Front end: holds the default attribute register, accepts and classifies transactions.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_func,
    input  wire logic [7:0]       i_char_code,
    input  wire logic [7:0]       i_color,
    input  wire logic [COL_W-1:0] i_col_pos,
    input  wire logic [ROW_W-1:0] i_row_pos,
    input  wire logic             i_cfg_we,
    input  wire logic [7:0]       i_cfg_wdata,
    input  wire logic             i_q_full,
    input  wire t_back_status     i_back_status,
    output logic                  o_busy,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [7:0] r_default_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= DEFAULT_ATTR_RST;
        end else if (i_cfg_we) begin
            r_default_attr <= i_cfg_wdata;
        end
    end

    assign o_busy = i_q_full | i_back_status.clearing;
    assign o_push = i_start & ~o_busy;

    // coordinates saturate to the last column / row
    always_comb begin
        o_cmd      = '0;
        o_cmd.ch   = i_char_code;
        o_cmd.attr = r_default_attr;
        o_cmd.col  = (i_col_pos > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : i_col_pos;
        o_cmd.row  = (i_row_pos > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : i_row_pos;
        case (i_func)
            FUNC_PUT: begin
                if (i_char_code == CHAR_NEWLINE) begin
                    o_cmd.op = OP_NEWLINE;
                end else if (i_char_code == CHAR_TAB) begin
                    o_cmd.op = OP_TAB;
                end else begin
                    o_cmd.op = OP_PUT;
                    if (i_color != 8'd0) begin
                        o_cmd.attr = i_color;
                    end
                end
            end
            FUNC_DELETE: o_cmd.op = OP_DELETE;
            FUNC_SETCUR: o_cmd.op = OP_SETCUR;
            FUNC_READ:   o_cmd.op = OP_READ;
            default:     o_cmd.op = OP_READ;
        endcase
    end

endmodule

`default_nettype wire

>>> src/tcw_cmd_queue.sv
// Short command queue between front and back end.
// Depends on tcw_pkg.
`default_nettype none

module tcw_cmd_queue
    import tcw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_cmd      o_cmd
);

    t_cmd              r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/tcw_back.sv
// Back end: screen memory, cursor and the sequencer that carries out each command.
// Depends on tcw_pkg and text_console_writer_top_macros.svh.
`default_nettype none
`include "text_console_writer_top_macros.svh"

module tcw_back
    import tcw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_cmd             i_q_cmd,
    output logic                  o_q_pop,
    output t_back_status          o_status,
    output logic                  o_strobe,
    output logic [COL_W-1:0]      o_cursor_col,
    output logic [ROW_W-1:0]      o_cursor_row,
    output logic [7:0]            o_cell_char,
    output logic [7:0]            o_cell_attr,
    output logic                  o_scrolled
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_TAB     = 8'b0000_0100,
        S_DEL     = 8'b0000_1000,
        S_DEL_CHK = 8'b0001_0000,
        S_READ    = 8'b0010_0000,
        S_SCROLL  = 8'b0100_0000,
        S_ZERO    = 8'b1000_0000
    } t_state;

    t_state             r_state,     n_state;
    logic [WALK_W-1:0]  r_addr,      n_addr;
    logic [CNT_W-1:0]   r_cnt,       n_cnt;
    logic [COL_W-1:0]   r_col,       n_col;
    logic [ROW_W-1:0]   r_row,       n_row;
    t_cmd               r_cmd,       n_cmd;
    logic               r_strobe,    n_strobe;
    logic [7:0]         r_cell_char, n_cell_char;
    logic [7:0]         r_cell_attr, n_cell_attr;
    logic               r_scrolled,  n_scrolled;

    logic [15:0]        r_screen [CELLS];
    logic [15:0]        r_rd_data;

    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [15:0]        mem_wdata;
    logic               mem_re;
    logic [MEM_AW-1:0]  mem_raddr;

    logic [MEM_AW-1:0]  cur_lin;
    logic [MEM_AW-1:0]  cmd_lin;
    logic               col_last;
    logic               row_last;
    logic [COL_W:0]     tab_sum;

    assign cur_lin  = MEM_AW'(r_row) * MEM_AW'(COLUMNS) + MEM_AW'(r_col);
    assign cmd_lin  = MEM_AW'(i_q_cmd.row) * MEM_AW'(COLUMNS) + MEM_AW'(i_q_cmd.col);
    assign col_last = (r_col == COL_W'(COLUMNS - 1));
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign tab_sum  = {1'b0, r_col} + (COL_W + 1)'(TAB_BLANKS + 1);

    // screen memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_screen[mem_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_row       = r_row;
        n_cmd       = r_cmd;
        n_strobe    = 1'b0;
        n_cell_char = 8'd0;
        n_cell_attr = 8'd0;
        n_scrolled  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = cur_lin;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = cur_lin;
        o_q_pop     = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr[MEM_AW-1:0];
                n_addr    = r_addr + WALK_W'(1);
                if (r_addr == WALK_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    case (i_q_cmd.op)
                        OP_PUT: begin
                            mem_we    = 1'b1;
                            mem_wdata = {i_q_cmd.attr, i_q_cmd.ch};
                            if (col_last) begin
                                n_col = '0;
                                if (row_last) begin
                                    n_addr  = WALK_W'(COLUMNS);
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row    = r_row + ROW_W'(1);
                                    n_strobe = 1'b1;
                                end
                            end else begin
                                n_col    = r_col + COL_W'(1);
                                n_strobe = 1'b1;
                            end
                        end
                        OP_NEWLINE: begin
                            n_col = '0;
                            if (row_last) begin
                                n_addr  = WALK_W'(COLUMNS);
                                n_state = S_SCROLL;
                            end else begin
                                n_row    = r_row + ROW_W'(1);
                                n_strobe = 1'b1;
                            end
                        end
                        OP_TAB: begin
                            n_addr  = WALK_W'(cur_lin);
                            n_cnt   = '0;
                            n_state = S_TAB;
                        end
                        OP_DELETE: begin
                            if (cur_lin == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_DEL;
                            end
                        end
                        OP_SETCUR: begin
                            n_col    = i_q_cmd.col;
                            n_row    = i_q_cmd.row;
                            n_strobe = 1'b1;
                        end
                        OP_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = cmd_lin;
                            n_state   = S_READ;
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            S_TAB: begin
                // blanks that fall past the last cell are dropped
                if (r_addr < WALK_W'(CELLS)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_addr[MEM_AW-1:0];
                    mem_wdata = {r_cmd.attr, CHAR_BLANK};
                end
                n_addr = r_addr + WALK_W'(1);
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TAB_BLANKS - 1)) begin
                    if (tab_sum >= (COL_W + 1)'(COLUMNS)) begin
                        n_col = COL_W'(tab_sum - (COL_W + 1)'(COLUMNS));
                        if (row_last) begin
                            n_addr  = WALK_W'(COLUMNS);
                            n_state = S_SCROLL;
                        end else begin
                            n_row    = r_row + ROW_W'(1);
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end else begin
                        n_col    = tab_sum[COL_W-1:0];
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_DEL: begin
                mem_we    = 1'b1;
                mem_waddr = cur_lin - MEM_AW'(1);
                mem_wdata = {r_cmd.attr, CHAR_NULL};
                if (r_col == '0) begin
                    n_col = COL_W'(COLUMNS - 1);
                    n_row = r_row - ROW_W'(1);
                end else begin
                    n_col = r_col - COL_W'(1);
                end
                if (cur_lin == MEM_AW'(1)) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    // look at the cell before the new cursor
                    mem_re    = 1'b1;
                    mem_raddr = cur_lin - MEM_AW'(2);
                    n_state   = S_DEL_CHK;
                end
            end
            S_DEL_CHK: begin
                if (r_rd_data[7:0] != CHAR_NULL) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_DEL;
                end
            end
            S_READ: begin
                n_strobe    = 1'b1;
                n_cell_char = r_rd_data[7:0];
                n_cell_attr = r_rd_data[15:8];
                n_state     = S_IDLE;
            end
            S_SCROLL: begin
                // read runs one row ahead; each cell is written in the cycle after it is read
                mem_re    = (r_addr < WALK_W'(CELLS));
                mem_raddr = r_addr[MEM_AW-1:0];
                mem_we    = (r_addr != WALK_W'(COLUMNS));
                mem_waddr = MEM_AW'(r_addr - WALK_W'(COLUMNS + 1));
                mem_wdata = r_rd_data;
                n_addr    = r_addr + WALK_W'(1);
                if (r_addr == WALK_W'(CELLS)) begin
                    n_addr  = WALK_W'(CELLS - COLUMNS);
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr[MEM_AW-1:0];
                n_addr    = r_addr + WALK_W'(1);
                if (r_addr == WALK_W'(CELLS - 1)) begin
                    n_strobe   = 1'b1;
                    n_scrolled = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_strobe    <= 1'b0;
            r_cell_char <= 8'd0;
            r_cell_attr <= 8'd0;
            r_scrolled  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_row       <= n_row;
            r_strobe    <= n_strobe;
            r_cell_char <= n_cell_char;
            r_cell_attr <= n_cell_attr;
            r_scrolled  <= n_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_strobe          = r_strobe;
    assign o_cursor_col      = r_col;
    assign o_cursor_row      = r_row;
    assign o_cell_char       = r_cell_char;
    assign o_cell_attr       = r_cell_attr;
    assign o_scrolled        = r_scrolled;

    `TCW_ASSERT_NOW(a_cursor_in_screen, 1'b1, (r_row <= ROW_W'(ROWS - 1)) && (r_col <= COL_W'(COLUMNS - 1)), "cursor left the screen")
    `TCW_ASSERT_NOW(a_write_in_screen, mem_we, mem_waddr < MEM_AW'(CELLS), "screen write out of range")
    `TCW_ASSERT_NOW(a_quiet_while_clearing, r_state == S_CLEAR, !r_strobe && !o_q_pop, "activity during clearing pass")
    `TCW_ASSERT_NEXT(a_scroll_reports, (r_state == S_ZERO) && (r_addr == WALK_W'(CELLS - 1)), r_strobe && r_scrolled && (r_state == S_IDLE), "scroll did not complete")

endmodule

`default_nettype wire

>>> src/text_console_writer_top.sv
// Text console writer top level: front end, command queue and back end.
// Depends on tcw_pkg, tcw_front, tcw_cmd_queue and tcw_back.
`default_nettype none

// Text console writer. Keeps an 80 x 25 screen of 16-bit cells (attribute in
// bits 15:8, character in 7:0) and a cursor. A transaction is taken on a rising
// edge with start high and busy low; each one yields exactly one result, shown
// for one cycle with o_strobe high. The receiver cannot stall: results must be
// captured in the strobe cycle. After reset the screen memory is swept to zero,
// one cell a cycle, and busy stays high throughout the sweep. In the back end
// (one write, one read port on the screen memory), put character, newline and
// set cursor finish in the command cycle bar a scroll; read cell reads memory,
// then returns the cell; tab writes one blank per cycle after the command
// cycle; delete clears a cell, then reads the one before it to decide whether
// to go on (no read once the walk reaches cell zero). A scroll moves every row
// up one, then zeroes the last row. A two-entry queue lets the front end keep
// taking transactions while the back end works, so after the sweep busy rises
// only when the queue is full. The user must see that default_attribute (reset
// 15) is written via i_cfg_we / i_cfg_wdata only while idle (not enforced).
module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       i_func,
    input  wire logic [7:0]       i_char_code,
    input  wire logic [7:0]       i_color,
    input  wire logic [COL_W-1:0] i_col_pos,
    input  wire logic [ROW_W-1:0] i_row_pos,
    input  wire logic             i_cfg_we,
    input  wire logic [7:0]       i_cfg_wdata,
    output logic                  o_strobe,
    output logic [COL_W-1:0]      o_cursor_col,
    output logic [ROW_W-1:0]      o_cursor_row,
    output logic [7:0]            o_cell_char,
    output logic [7:0]            o_cell_attr,
    output logic                  o_scrolled
);

    logic         push;
    t_cmd         push_cmd;
    logic         q_full;
    logic         q_valid;
    t_cmd         q_cmd;
    logic         q_pop;
    t_back_status back_status;

    // classifies the transaction, resolves attribute and clamps coordinates
    tcw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_func        (i_func),
        .i_char_code   (i_char_code),
        .i_color       (i_color),
        .i_col_pos     (i_col_pos),
        .i_row_pos     (i_row_pos),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_full      (q_full),
        .i_back_status (back_status),
        .o_busy        (busy),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    tcw_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    // executes commands against the screen memory, produces results in order
    tcw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_status     (back_status),
        .o_strobe     (o_strobe),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_scrolled   (o_scrolled)
    );

endmodule

`default_nettype wire

>>> sim/console_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the text console writer: screen, cursor and default-attribute predictor
// plus the in-order checker of results. Depends on tcw_pkg only.
package console_check_pkg;
    import tcw_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       ch;
        logic [7:0]       attr;
        logic             scrolled;
    } t_console_result;

    class console_scoreboard;
        logic [15:0]     cells [CELLS];   // attribute in 15:8, character in 7:0
        int unsigned     cursor;
        logic [7:0]      default_attr;
        t_console_result awaited_results [$];
        int unsigned     fails;
        int unsigned     results_seen;
        int unsigned     scrolls;
        int unsigned     by_func [4];

        function new();
            foreach (cells[k]) cells[k] = '0;
            cursor       = 0;
            default_attr = DEFAULT_ATTR_RST;
        endfunction

        function void report(string what);
            fails++;
            $display("mismatch: %s", what);
        endfunction

        // out-of-range coordinates clamp to the last column / row
        function int unsigned cell_index(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
            int unsigned c;
            int unsigned r;
            c = (col > COLUMNS - 1) ? COLUMNS - 1 : col;
            r = (row > ROWS - 1) ? ROWS - 1 : row;
            return r * COLUMNS + c;
        endfunction

        // Called once per accepted transaction; queues the result it must give.
        function void note_command(logic [1:0] func, logic [7:0] ch, logic [7:0] color,
                                   logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
            int unsigned     cur;
            int unsigned     k;
            logic [15:0]     rd_cell;
            t_console_result view;
            cur  = (cursor >= CELLS) ? CELLS - 1 : cursor;
            view = '0;
            by_func[func]++;
            case (func)
                FUNC_PUT: begin
                    if (ch == CHAR_NEWLINE) begin
                        cur = (cur / COLUMNS + 1) * COLUMNS;
                    end else if (ch == CHAR_TAB) begin
                        for (k = 0; k < TAB_BLANKS; k++)
                            if (cur + k < CELLS) cells[cur + k] = {default_attr, CHAR_BLANK};
                        cur += TAB_BLANKS + 1;
                    end else begin
                        cells[cur] = {(color != 8'd0) ? color : default_attr, ch};
                        cur += 1;
                    end
                    if (cur >= CELLS) begin
                        // one row up per transaction, last row zeroed
                        for (k = 0; k < CELLS - COLUMNS; k++) cells[k] = cells[k + COLUMNS];
                        for (k = CELLS - COLUMNS; k < CELLS; k++) cells[k] = '0;
                        cur -= COLUMNS;
                        if (cur >= CELLS) cur = CELLS - 1;
                        view.scrolled = 1'b1;
                        scrolls++;
                    end
                end
                FUNC_DELETE: begin
                    // clear backwards while the preceding character is null
                    while (cur > 0) begin
                        cur -= 1;
                        cells[cur] = {default_attr, CHAR_NULL};
                        if (cur == 0 || cells[cur - 1][7:0] != CHAR_NULL) break;
                    end
                end
                FUNC_SETCUR: begin
                    cur = cell_index(col, row);
                end
                default: begin
                    rd_cell   = cells[cell_index(col, row)];
                    view.ch   = rd_cell[7:0];
                    view.attr = rd_cell[15:8];
                end
            endcase
            cursor   = cur;
            view.col = COL_W'(cur % COLUMNS);
            view.row = ROW_W'(cur / COLUMNS);
            awaited_results.push_back(view);
        endfunction

        function void check_result(t_console_result got);
            t_console_result want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report($sformatf("result %0d arrived with no transaction outstanding",
                                 results_seen));
                return;
            end
            want = awaited_results.pop_front();
            if (got.col != want.col)
                report($sformatf("result %0d cursor_col %0d, want %0d",
                                 results_seen, got.col, want.col));
            if (got.row != want.row)
                report($sformatf("result %0d cursor_row %0d, want %0d",
                                 results_seen, got.row, want.row));
            if (got.ch != want.ch)
                report($sformatf("result %0d cell_char %h, want %h",
                                 results_seen, got.ch, want.ch));
            if (got.attr != want.attr)
                report($sformatf("result %0d cell_attr %h, want %h",
                                 results_seen, got.attr, want.attr));
            if (got.scrolled != want.scrolled)
                report($sformatf("result %0d scrolled %b, want %b",
                                 results_seen, got.scrolled, want.scrolled));
        endfunction
    endclass

endpackage

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer_top: directed and random transactions.
// Depends on tcw_pkg, console_check_pkg and the text console writer RTL.
module testbench;
    import tcw_pkg::*;
    import console_check_pkg::*;

    // Generous cap: the worst case is a whole-screen delete walk on every transaction,
    // plus idle bursts and the clearing sweep after reset.
    localparam int unsigned CYCLE_LIMIT   = 20_000_000;
    localparam int          PHASES        = 4;
    localparam int          PHASE_ITEMS   = 250;   // 1000 random transactions in all
    localparam int          SETTLE_CYCLES = 50;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    logic [1:0]       i_func      = FUNC_PUT;
    logic [7:0]       i_char_code = 8'd0;
    logic [7:0]       i_color     = 8'd0;
    logic [COL_W-1:0] i_col_pos   = '0;
    logic [ROW_W-1:0] i_row_pos   = '0;
    logic             i_cfg_we    = 1'b0;
    logic [7:0]       i_cfg_wdata = 8'd0;
    logic             o_strobe;
    logic [COL_W-1:0] o_cursor_col;
    logic [ROW_W-1:0] o_cursor_row;
    logic [7:0]       o_cell_char;
    logic [7:0]       o_cell_attr;
    logic             o_scrolled;

    console_scoreboard board;
    int unsigned       cycles        = 0;
    int unsigned       attr_settings = 0;

    always #10 i_clk = ~i_clk;

    text_console_writer_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_color      (i_color),
        .i_col_pos    (i_col_pos),
        .i_row_pos    (i_row_pos),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_strobe     (o_strobe),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_scrolled   (o_scrolled)
    );

    // Watchdog: a hung block ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycles);
            $display("[text_console_writer_top] ERROR");
            $finish;
        end
    end

    // Result monitor: the strobe lasts one cycle and cannot be held off, so every
    // rising edge with the strobe high is a result transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_result('{o_cursor_col, o_cursor_row, o_cell_char, o_cell_attr,
                                 o_scrolled});
    end

    // One command transaction: inputs set up at the falling edge, held until a rising
    // edge sees busy low. The prediction is made at that same edge.
    task automatic send_cmd(input logic [1:0] func, input logic [7:0] ch,
                            input logic [7:0] color, input logic [COL_W-1:0] col,
                            input logic [ROW_W-1:0] row);
        @(negedge i_clk);
        start       = 1'b1;
        i_func      = func;
        i_char_code = ch;
        i_color     = color;
        i_col_pos   = col;
        i_row_pos   = row;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_command(func, ch, color, col, row);
    endtask

    // Sender idle burst; the payload is scrambled so that nothing leaks through
    // while start is low.
    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start       = 1'b0;
            i_func      = 2'($urandom);
            i_char_code = 8'($urandom);
            i_color     = 8'($urandom);
            i_col_pos   = COL_W'($urandom);
            i_row_pos   = ROW_W'($urandom);
        end
    endtask

    // Hold off until every outstanding result has come back, then let the back end settle.
    task automatic drain;
        @(negedge i_clk);
        start = 1'b0;
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_default_attr(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 8'($urandom);
        board.default_attr = value;
        attr_settings++;
    endtask

    // Mostly text output with the odd control character, cursor move, delete and read.
    // At least a third of cursor moves land on (or clamp to) the last row so that scrolling
    // happens often without dominating the run time.
    task automatic random_command;
        logic [1:0]       func;
        logic [7:0]       ch;
        logic [7:0]       color;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        int unsigned      pick;
        int unsigned      sub;
        ch    = 8'($urandom);
        color = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        col   = COL_W'($urandom);
        row   = ROW_W'($urandom);
        pick  = $urandom_range(0, 99);
        sub   = $urandom_range(0, 99);
        if (pick < 60) begin
            func = FUNC_PUT;
            if (sub < 8)       ch = CHAR_NEWLINE;
            else if (sub < 16) ch = CHAR_TAB;
            else if (sub < 20) ch = CHAR_NULL;
        end else if (pick < 70) begin
            func = FUNC_DELETE;
        end else if (pick < 82) begin
            func = FUNC_SETCUR;
            if (sub < 33) row = ROW_W'($urandom_range(ROWS - 1, 31));
        end else begin
            func = FUNC_READ;
        end
        send_cmd(func, ch, color, col, row);
    endtask

    initial begin
        logic [7:0] attr_plan [PHASES];
        bit         calm;
        board = new();

        // synchronous reset first; the clearing sweep that follows is covered
        // by the busy handshake of the first transaction
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: default colour, null and 0xFF characters, tab, newline, delete walks,
        // delete at cell zero, clamped coordinates, scroll by put, newline and tab.
        send_cmd(FUNC_READ,   8'h00,        8'h00, 7'd0,   5'd0);
        send_cmd(FUNC_PUT,    8'h41,        8'h00, 7'd0,   5'd0);
        send_cmd(FUNC_PUT,    CHAR_NULL,    8'hFF, 7'd0,   5'd0);
        send_cmd(FUNC_PUT,    8'hFF,        8'h80, 7'd0,   5'd0);
        send_cmd(FUNC_PUT,    CHAR_TAB,     8'h01, 7'd0,   5'd0);
        send_cmd(FUNC_READ,   8'h00,        8'h00, 7'd3,   5'd0);
        send_cmd(FUNC_PUT,    CHAR_NEWLINE, 8'h00, 7'd0,   5'd0);
        send_cmd(FUNC_DELETE, 8'h00,        8'h00, 7'd0,   5'd0);   // long walk back to the tab
        send_cmd(FUNC_DELETE, 8'h00,        8'h00, 7'd0,   5'd0);
        send_cmd(FUNC_SETCUR, 8'h00,        8'h00, 7'd1,   5'd0);
        send_cmd(FUNC_DELETE, 8'h00,        8'h00, 7'd0,   5'd0);   // stops on cell zero
        send_cmd(FUNC_DELETE, 8'h00,        8'h00, 7'd0,   5'd0);   // already at cell zero
        send_cmd(FUNC_SETCUR, 8'h00,        8'h00, 7'd127, 5'd31);  // clamps to the last cell
        send_cmd(FUNC_READ,   8'h00,        8'h00, 7'd127, 5'd31);
        send_cmd(FUNC_PUT,    8'h5A,        8'h4E, 7'd0,   5'd0);   // last cell, scrolls
        send_cmd(FUNC_PUT,    CHAR_NEWLINE, 8'h00, 7'd0,   5'd0);   // last row, scrolls
        send_cmd(FUNC_SETCUR, 8'h00,        8'h00, 7'd79,  5'd24);
        send_cmd(FUNC_PUT,    CHAR_TAB,     8'h00, 7'd0,   5'd0);   // blanks past the end dropped
        send_cmd(FUNC_SETCUR, 8'h00,        8'h00, 7'd77,  5'd24);
        send_cmd(FUNC_PUT,    CHAR_TAB,     8'h00, 7'd0,   5'd0);
        send_cmd(FUNC_READ,   8'h00,        8'h00, 7'd79,  5'd23);
        send_cmd(FUNC_SETCUR, 8'h00,        8'h00, 7'd0,   5'd31);
        send_cmd(FUNC_READ,   8'h00,        8'h00, 7'd0,   5'd24);
        send_cmd(FUNC_READ,   8'h00,        8'h00, 7'd127, 5'd0);

        // Random phases, each under its own default attribute (both extremes first).
        // The drain before each write is also the point where the sender waits for
        // every outstanding result.
        attr_plan[0] = 8'hFF;
        attr_plan[1] = 8'h00;
        attr_plan[2] = 8'($urandom_range(1, 254));
        attr_plan[3] = 8'($urandom_range(1, 254));
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_default_attr(attr_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // no idling in the last phase, nor in a stretch of each hundred
                calm = (p == PHASES - 1) || (n % 100 < 20);
                if (!calm && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 14));
                random_command();
            end
        end

        drain();
        $display("covered %0d transactions: %0d puts, %0d deletes, %0d cursor moves, %0d reads",
                 board.by_func[FUNC_PUT] + board.by_func[FUNC_DELETE] +
                 board.by_func[FUNC_SETCUR] + board.by_func[FUNC_READ],
                 board.by_func[FUNC_PUT], board.by_func[FUNC_DELETE],
                 board.by_func[FUNC_SETCUR], board.by_func[FUNC_READ]);
        $display("%0d results checked, %0d scrolls, %0d attribute settings, %0d mismatches",
                 board.results_seen, board.scrolls, attr_settings, board.fails);
        if (board.fails == 0) begin
            $display("[text_console_writer_top] OK");
        end else begin
            $display("[text_console_writer_top] ERROR");
        end
        $finish;
    end

endmodule
